@@ sv/fsq_pkg.sv @@
// fsq_pkg: types, constants and limit look-ups for the fault source qualifier
// used by fsq_judge, fault_source_qualifier and fsq_checker; no dependencies
package fsq_pkg;

  localparam int NUM_SOURCES_DEF = 13;
  localparam int SRC_W           = 4;
  localparam int OCC_W           = 8;
  localparam int TIME_W          = 32;
  localparam int TMO_W           = 16;
  localparam int DATA_W          = 64;
  localparam int ADDR_W          = 5;

  localparam logic [OCC_W-1:0] OCC_MAX = 8'hFF;

  localparam logic [12:0] CARE_RST    = 13'h1FAF;
  localparam logic [39:0] CNT_LIM_RST = 40'h03_0303_0303;
  localparam logic [63:0] TMO_RST     = 64'h03E8_03E8_03E8_03E8;

  // register index, taken from paddr above the 8-byte offset
  localparam logic [1:0] REG_CARE    = 2'd0;
  localparam logic [1:0] REG_CNT_LIM = 2'd1;
  localparam logic [1:0] REG_TMO_LO  = 2'd2;
  localparam logic [1:0] REG_TMO_HI  = 2'd3;

  typedef enum logic [2:0] {
    OP_REPORT    = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_TICK      = 3'd2,
    OP_CHECK_ONE = 3'd3,
    OP_CHECK_ALL = 3'd4,
    OP_STATUS    = 3'd5
  } fsq_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_STATUS
  } fsq_state_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [SRC_W-1:0] source_id;
    logic             force_en;
  } fsq_in_t;

  typedef struct packed {
    logic             fault;
    logic             handling;
    logic             active;
    logic [OCC_W-1:0] occurrences;
  } fsq_out_t;

  typedef struct packed {
    logic fault;   // active and past its limit
    logic hold;    // active and within limit: set handling
    logic drop;    // inactive: clear handling
  } fsq_verdict_t;

  function automatic logic is_timed(input logic [SRC_W-1:0] src);
    return (src >= 4'd3) && (src <= 4'd10);
  endfunction

  function automatic logic [OCC_W-1:0] cnt_limit(input logic [SRC_W-1:0] src,
                                                 input logic [39:0]      lims);
    logic [OCC_W-1:0] lim;
    case (src)
      4'd0:    lim = lims[7:0];
      4'd1:    lim = lims[15:8];
      4'd2:    lim = lims[23:16];
      4'd11:   lim = lims[31:24];
      4'd12:   lim = lims[39:32];
      default: lim = '0;
    endcase
    return lim;
  endfunction

  function automatic logic [TMO_W-1:0] tmo_limit(input logic [SRC_W-1:0]  src,
                                                 input logic [DATA_W-1:0] lo,
                                                 input logic [DATA_W-1:0] hi);
    logic [TMO_W-1:0] lim;
    case (src)
      4'd3:    lim = lo[15:0];
      4'd4:    lim = lo[31:16];
      4'd5:    lim = lo[47:32];
      4'd6:    lim = lo[63:48];
      4'd7:    lim = hi[15:0];
      4'd8:    lim = hi[31:16];
      4'd9:    lim = hi[47:32];
      4'd10:   lim = hi[63:48];
      default: lim = '0;
    endcase
    return lim;
  endfunction

endpackage

@@ sv/fsq_judge.sv @@
// fsq_judge: shared compare unit that judges one source entry per cycle
// depends on fsq_pkg for limit look-ups and the verdict struct
module fsq_judge import fsq_pkg::*; (
  input  logic [SRC_W-1:0]  src,
  input  logic              active,
  input  logic [TIME_W-1:0] onset,
  input  logic [OCC_W-1:0]  count,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [39:0]       count_limits,
  input  logic [DATA_W-1:0] tmo_lo,
  input  logic [DATA_W-1:0] tmo_hi,
  output fsq_verdict_t      verdict
);

  logic [TIME_W-1:0] elapsed;
  logic              in_lim;

  // elapsed time wraps with the millisecond clock
  assign elapsed = now_ms - onset;

  always_comb begin
    if (is_timed(src)) begin
      in_lim = elapsed < TIME_W'(tmo_limit(src, tmo_lo, tmo_hi));
    end else begin
      in_lim = count < cnt_limit(src, count_limits);
    end
    verdict.fault = active & ~in_lim;
    verdict.hold  = active & in_lim;
    verdict.drop  = ~active;
  end

endmodule

@@ sv/fault_source_qualifier.sv @@
// fault_source_qualifier: top level, sequencer, source state and register port
// depends on fsq_pkg and fsq_judge
//
// Qualifies NUM_SOURCES fault sources. Each input word (report, clear, tick,
// check one, check all, read status) gives exactly one result word holding
// the fault verdict and the status of the addressed source. Source state sits
// in a small table that one shared judge unit reads at a single index under a
// four-state sequencer. Report, clear, tick, check one and status pass through
// the execute and then the status state; check all walks the table one source
// a cycle, ending early at the first fault of a source set in the care mask.
// The block takes a new word once the previous one has been handed to the
// result register, which may still be waiting on out_ready. Registers sit at
// byte addresses 0, 8, 16 and 24 of a 64-bit APB port with no wait states.
module fault_source_qualifier import fsq_pkg::*; #(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fsq_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fsq_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W = $clog2(NUM_SOURCES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);

  fsq_state_t state_r, state_nxt;

  logic [2:0]             op_r;
  logic [SRC_W-1:0]       sid_r;
  logic                   force_r;
  logic                   fault_r, fault_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [TIME_W-1:0]      now_r;

  logic [NUM_SOURCES-1:0] care_r;
  logic [39:0]            cnt_lim_r;
  logic [DATA_W-1:0]      tmo_lo_r;
  logic [DATA_W-1:0]      tmo_hi_r;

  logic [NUM_SOURCES-1:0] active_r;
  logic [NUM_SOURCES-1:0] handling_r;
  logic [TIME_W-1:0]      onset_r [NUM_SOURCES];
  logic [OCC_W-1:0]       count_r [NUM_SOURCES];

  logic                   out_valid_r;
  fsq_out_t               out_r;

  logic                   accept;
  logic                   sid_ok;
  logic                   rep_en, clr_en, tick_en, judge_en, load_out;
  logic                   cfg_wr;
  logic [1:0]             reg_idx;
  fsq_verdict_t           verdict;

  assign accept   = in_valid & in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign sid_ok   = int'(sid_r) < NUM_SOURCES;
  assign reg_idx  = paddr[ADDR_W-1:3];
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign pready   = 1'b1;

  fsq_judge u_judge (
    .src          (SRC_W'(idx_r)),
    .active       (active_r[idx_r]),
    .onset        (onset_r[idx_r]),
    .count        (count_r[idx_r]),
    .now_ms       (now_r),
    .count_limits (cnt_lim_r),
    .tmo_lo       (tmo_lo_r),
    .tmo_hi       (tmo_hi_r),
    .verdict      (verdict)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.opcode == OP_CHECK_ALL) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_STATUS;
      end
      ST_SCAN: begin
        if ((care_r[idx_r] && verdict.fault) || (idx_r == LAST_IDX)) begin
          state_nxt = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    idx_nxt   = idx_r;
    fault_nxt = fault_r;
    rep_en    = 1'b0;
    clr_en    = 1'b0;
    tick_en   = 1'b0;
    judge_en  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          fault_nxt = 1'b0;
          idx_nxt   = (in_data.opcode == OP_CHECK_ALL) ? '0 : IDX_W'(in_data.source_id);
        end
      end
      ST_EXEC: begin
        case (op_r)
          OP_REPORT:    rep_en  = sid_ok;
          OP_CLEAR:     clr_en  = sid_ok;
          OP_TICK:      tick_en = 1'b1;
          OP_CHECK_ONE: begin
            judge_en = sid_ok && (care_r[idx_r] || force_r);
            if (judge_en) begin
              fault_nxt = verdict.fault;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        judge_en = care_r[idx_r];
        if (care_r[idx_r] && verdict.fault) begin
          fault_nxt = 1'b1;
          idx_nxt   = IDX_W'(sid_r);
        end else if (idx_r == LAST_IDX) begin
          idx_nxt = IDX_W'(sid_r);
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_STATUS: begin
        load_out = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fault_r <= 1'b0;
      idx_r   <= '0;
      now_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fault_r <= fault_nxt;
      idx_r   <= idx_nxt;
      if (tick_en) begin
        now_r <= now_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_data.opcode;
      sid_r   <= in_data.source_id;
      force_r <= in_data.force_en;
    end
  end

  // source table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= '0;
      handling_r <= '0;
      count_r    <= '{default: '0};
    end else begin
      if (rep_en) begin
        if (!active_r[idx_r]) begin
          active_r[idx_r] <= 1'b1;
          count_r[idx_r]  <= OCC_W'(1);
        end else if (count_r[idx_r] != OCC_MAX) begin
          count_r[idx_r] <= count_r[idx_r] + 1'b1;
        end
      end
      if (clr_en) begin
        active_r[idx_r] <= 1'b0;
      end
      if (judge_en) begin
        if (verdict.drop) begin
          handling_r[idx_r] <= 1'b0;
        end else if (verdict.hold) begin
          handling_r[idx_r] <= 1'b1;
        end
      end
    end
  end

  // onset stamp is only read while the source is active
  always_ff @(posedge clk) begin
    if (rep_en && !active_r[idx_r]) begin
      onset_r[idx_r] <= now_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.fault       <= fault_r;
      out_r.handling    <= sid_ok & handling_r[idx_r];
      out_r.active      <= sid_ok & active_r[idx_r];
      out_r.occurrences <= sid_ok ? count_r[idx_r] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      care_r    <= NUM_SOURCES'(CARE_RST);
      cnt_lim_r <= CNT_LIM_RST;
      tmo_lo_r  <= TMO_RST;
      tmo_hi_r  <= TMO_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CARE:    care_r    <= pwdata[NUM_SOURCES-1:0];
        REG_CNT_LIM: cnt_lim_r <= pwdata[39:0];
        REG_TMO_LO:  tmo_lo_r  <= pwdata;
        REG_TMO_HI:  tmo_hi_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CARE:    prdata = DATA_W'(care_r);
      REG_CNT_LIM: prdata = DATA_W'(cnt_lim_r);
      REG_TMO_LO:  prdata = tmo_lo_r;
      REG_TMO_HI:  prdata = tmo_hi_r;
      default:     prdata = '0;
    endcase
  end

endmodule

@@ sv/fsq_checker.sv @@
// fsq_checker: port-level assertions for fault_source_qualifier, with its bind
// depends on fsq_pkg for the word types
module fsq_checker import fsq_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input fsq_out_t out_data,
  input logic     pready
);

  // a word in flight keeps the input closed while the sequencer works on it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input reopened too early after a word was taken");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // an active source has been reported at least once
  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.active |-> out_data.occurrences != '0)
    else $error("active source with zero occurrences");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("register port inserted a wait state");

endmodule

bind fault_source_qualifier fsq_checker u_fsq_checker (.*);
